// ===== src/drp_pkg.sv =====
// Shared types and constants for the disparity reprojection block.
package drp_pkg;

   // Configuration register indexes
   typedef enum logic [2:0] {
      REG_OFFSET_X         = 3'd0,
      REG_OFFSET_Y         = 3'd1,
      REG_FOCAL_TERM       = 3'd2,
      REG_INVERSE_BASELINE = 3'd3,
      REG_WEIGHT_OFFSET    = 3'd4
   } reg_index_type;

   // Register file contents as seen by the front part
   typedef struct packed {
      logic [31:0] offset_x;
      logic [31:0] offset_y;
      logic [31:0] focal_term;
      logic [31:0] inverse_baseline;
      logic [31:0] weight_offset;
   } cfg_type;

   localparam int          CfgBits     = 32;
   localparam logic [31:0] WeightReset = 32'h0001_0000;
   // Weight w = weight_offset - d * inverse_baseline fits 42 bits signed
   localparam int          DenBits     = 42;
   // Quotient bits developed by the divider; anything above is overflow
   localparam int          QuoBits     = 33;
   localparam logic [31:0] QMax        = 32'h7FFF_FFFF;
   localparam logic [31:0] QMin        = 32'h8000_0000;
   localparam int          Lanes       = 3;

endpackage

// ===== src/drp_front.sv =====
// Front part: drops invalid pixels, forms the weight and the three numerators.
module drp_front #(
   parameter int FracBits = 16,
   parameter int CoordBits = 12,
   parameter int NumBits = 34
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  logic [7:0]                disparity,
   input  logic [CoordBits-1:0]      column,
   input  logic [CoordBits-1:0]      row,
   input  logic [23:0]               color,
   input  drp_pkg::cfg_type          cfg,
   output logic                      out_valid,
   output logic [drp_pkg::DenBits-1:0] den_mag,
   output logic                      den_neg,
   output logic                      den_zero,
   output logic [NumBits-1:0]        num_mag [drp_pkg::Lanes],
   output logic [drp_pkg::Lanes-1:0] num_neg,
   output logic [23:0]               out_color
);
   import drp_pkg::*;

   logic                  v1_ff, v1_in;
   logic signed [40:0]    prod_ff, prod_in;
   logic [CoordBits-1:0]  col_ff, row_ff;
   logic [23:0]           color_ff;

   logic signed [DenBits-1:0] w;
   logic signed [NumBits-1:0] num [Lanes];

   logic                      v2_ff;
   logic [DenBits-1:0]        den_mag_ff;
   logic                      den_neg_ff, den_zero_ff;
   logic [NumBits-1:0]        num_mag_ff [Lanes];
   logic [Lanes-1:0]          num_neg_ff;
   logic [23:0]               color2_ff;

   // Drop zero disparity; multiply disparity by the baseline term
   assign v1_in   = in_valid && (disparity != 8'd0);
   assign prod_in = 41'($signed({1'b0, disparity})) * 41'($signed(cfg.inverse_baseline));

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
      end
      prod_ff  <= prod_in;
      col_ff   <= column;
      row_ff   <= row;
      color_ff <= color;
   end

   // Form weight and numerators exactly
   always_comb begin
      w = $signed({{(DenBits-32){cfg.weight_offset[31]}}, cfg.weight_offset})
          - $signed({prod_ff[40], prod_ff});
      num[0] = $signed(NumBits'(col_ff) << FracBits)
               + $signed({{(NumBits-32){cfg.offset_x[31]}}, cfg.offset_x});
      num[1] = $signed(NumBits'(row_ff) << FracBits)
               + $signed({{(NumBits-32){cfg.offset_y[31]}}, cfg.offset_y});
      num[2] = $signed({{(NumBits-32){cfg.focal_term[31]}}, cfg.focal_term});
   end

   // Register magnitudes and signs
   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      den_mag_ff  <= w[DenBits-1] ? DenBits'(-w) : DenBits'(w);
      den_neg_ff  <= w[DenBits-1];
      den_zero_ff <= (w == '0);
      for (int i = 0; i < Lanes; i++) begin
         num_mag_ff[i] <= num[i][NumBits-1] ? NumBits'(-num[i]) : NumBits'(num[i]);
         num_neg_ff[i] <= num[i][NumBits-1];
      end
      color2_ff <= color_ff;
   end

   assign out_valid = v2_ff;
   assign den_mag   = den_mag_ff;
   assign den_neg   = den_neg_ff;
   assign den_zero  = den_zero_ff;
   assign num_mag   = num_mag_ff;
   assign num_neg   = num_neg_ff;
   assign out_color = color2_ff;

endmodule

// ===== src/drp_queue.sv =====
// Short queue between the front and back parts.
module drp_queue #(
   parameter int Width = 8,
   parameter int Depth = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [Width-1:0] push_data,
   input  logic             pop,
   output logic [Width-1:0] head_data,
   output logic             not_empty,
   output logic             full
);
   import drp_pkg::*;

   localparam int PtrBits = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntBits = $clog2(Depth + 1);

   logic [Width-1:0]   mem_ff [Depth];
   logic [PtrBits-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CntBits-1:0] cnt_ff, cnt_in;
   logic               do_push, do_pop;

   assign do_push = push && !full;
   assign do_pop  = pop && not_empty;

   // Advance pointers with wrap
   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == PtrBits'(Depth - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == PtrBits'(Depth - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (do_push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

   assign head_data = mem_ff[rd_ff];
   assign not_empty = (cnt_ff != '0);
   assign full      = (cnt_ff == CntBits'(Depth));

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CntBits'(Depth))
      else $error("queue count beyond depth");
   a_no_lost_push: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("transfer pushed into full queue");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (cnt_ff == $past(cnt_ff) + 1'b1))
      else $error("queue count did not advance on push");

endmodule

// ===== src/drp_back.sv =====
// Back part: three pipelined restoring dividers, one quotient bit per stage.
module drp_back #(
   parameter int FracBits = 16,
   parameter int NumBits = 34
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  logic [drp_pkg::DenBits-1:0] den_mag,
   input  logic                        den_neg,
   input  logic                        den_zero,
   input  logic [NumBits-1:0]          num_mag [drp_pkg::Lanes],
   input  logic [drp_pkg::Lanes-1:0]   num_neg,
   input  logic [23:0]                 in_color,
   output logic                        out_valid,
   output logic [31:0]                 point [drp_pkg::Lanes],
   output logic [23:0]                 out_color,
   output logic                        out_zero
);
   import drp_pkg::*;

   localparam int DivBits = NumBits + FracBits;
   localparam int TopBits = DivBits - QuoBits;
   localparam int RemBits = DenBits + 1;
   localparam int CmpBits = (TopBits > RemBits) ? TopBits : RemBits;

   logic               v_ff    [QuoBits+1];
   logic [DenBits-1:0] den_ff  [QuoBits+1];
   logic               dz_ff   [QuoBits+1];
   logic [Lanes-1:0]   neg_ff  [QuoBits+1];
   logic [Lanes-1:0]   ovf_ff  [QuoBits+1];
   logic [23:0]        col_ff  [QuoBits+1];
   logic [RemBits-1:0] rem_ff  [QuoBits+1][Lanes];
   logic [QuoBits-1:0] low_ff  [QuoBits+1][Lanes];
   logic [QuoBits-1:0] quo_ff  [QuoBits+1][Lanes];

   logic [DivBits-1:0] dividend [Lanes];
   logic [TopBits-1:0] top      [Lanes];

   // Split dividends and flag quotients that cannot fit
   always_comb begin
      for (int i = 0; i < Lanes; i++) begin
         dividend[i] = {num_mag[i], {FracBits{1'b0}}};
         top[i]      = dividend[i][DivBits-1:QuoBits];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else begin
         v_ff[0] <= in_valid;
      end
      den_ff[0] <= den_mag;
      dz_ff[0]  <= den_zero;
      col_ff[0] <= in_color;
      for (int i = 0; i < Lanes; i++) begin
         neg_ff[0][i] <= num_neg[i] ^ den_neg;
         ovf_ff[0][i] <= CmpBits'(top[i]) >= CmpBits'(den_mag);
         rem_ff[0][i] <= RemBits'(top[i]);
         low_ff[0][i] <= dividend[i][QuoBits-1:0];
         quo_ff[0][i] <= '0;
      end
   end

   // Develop one quotient bit per stage
   for (genvar s = 1; s <= QuoBits; s++) begin : g_stage
      logic [RemBits-1:0] shifted [Lanes];
      logic [RemBits-1:0] diff    [Lanes];
      logic [Lanes-1:0]   fits;

      always_comb begin
         for (int i = 0; i < Lanes; i++) begin
            shifted[i] = {rem_ff[s-1][i][RemBits-2:0], low_ff[s-1][i][QuoBits-1]};
            diff[i]    = shifted[i] - RemBits'(den_ff[s-1]);
            fits[i]    = shifted[i] >= RemBits'(den_ff[s-1]);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s] <= 1'b0;
         end else begin
            v_ff[s] <= v_ff[s-1];
         end
         den_ff[s] <= den_ff[s-1];
         dz_ff[s]  <= dz_ff[s-1];
         neg_ff[s] <= neg_ff[s-1];
         ovf_ff[s] <= ovf_ff[s-1];
         col_ff[s] <= col_ff[s-1];
         for (int i = 0; i < Lanes; i++) begin
            rem_ff[s][i] <= fits[i] ? diff[i] : shifted[i];
            low_ff[s][i] <= {low_ff[s-1][i][QuoBits-2:0], 1'b0};
            quo_ff[s][i] <= {quo_ff[s-1][i][QuoBits-2:0], fits[i]};
         end
      end
   end

   // Saturate and register the result
   logic               rv_ff;
   logic [31:0]        pt_ff [Lanes];
   logic [31:0]        pt_in [Lanes];
   logic [23:0]        rc_ff;
   logic               rz_ff;
   logic [QuoBits-1:0] q;

   // With a zero weight the weight sign bit is zero, so the lane sign is the numerator sign
   always_comb begin
      q = '0;
      for (int i = 0; i < Lanes; i++) begin
         q = quo_ff[QuoBits][i];
         if (dz_ff[QuoBits]) begin
            pt_in[i] = neg_ff[QuoBits][i] ? QMin : QMax;
         end else if (!neg_ff[QuoBits][i]) begin
            pt_in[i] = (ovf_ff[QuoBits][i] || q > QuoBits'(QMax)) ? QMax : q[31:0];
         end else begin
            pt_in[i] = (ovf_ff[QuoBits][i] || q > QuoBits'(QMin)) ? QMin : 32'(-q);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff <= 1'b0;
      end else begin
         rv_ff <= v_ff[QuoBits];
      end
      pt_ff <= pt_in;
      rc_ff <= col_ff[QuoBits];
      rz_ff <= dz_ff[QuoBits];
   end

   assign out_valid = rv_ff;
   assign point     = pt_ff;
   assign out_color = rc_ff;
   assign out_zero  = rz_ff;

   a_zero_saturates: assert property (@(posedge clock) disable iff (reset)
      (rv_ff && rz_ff) |-> ((pt_ff[2] == QMax) || (pt_ff[2] == QMin)))
      else $error("zero weight result not saturated");
   a_latency: assert property (@(posedge clock) disable iff (reset)
      v_ff[QuoBits] |=> rv_ff)
      else $error("divider result lost at output");
   a_ovf_sat: assert property (@(posedge clock) disable iff (reset)
      (v_ff[QuoBits] && ovf_ff[QuoBits][0] && !dz_ff[QuoBits])
      |=> ((pt_ff[0] == QMax) || (pt_ff[0] == QMin)))
      else $error("overflowed quotient not saturated");

endmodule

// ===== src/disparity_to_point_reprojection.sv =====
// Top level of the disparity-to-point reprojection block.
//
//  port group  direction  handshake            payload
//  req_        in         start & !busy        disparity, column, row, blue, green, red
//  rsp_        out        rsp_valid strobe     point_x/y/z, packed_color, zero_weight
//  csr_        in         csr_we               csr_index, csr_wdata
//
// One pixel is taken every clock while busy is low; a result passes through two
// front stages, the queue, one setup stage, 33 divider stages and the output.
// Latency is set by the bit-per-stage dividers. Zero-disparity pixels give no
// result. Reset clears the registers to their defaults and empties the
// pipeline. The receiver cannot stall, so the queue drains every cycle and
// busy stays low in practice.
module disparity_to_point_reprojection #(
   parameter int FRAC_BITS = 16,
   parameter int COORD_BITS = 12
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [7:0]            req_disparity,
   input  logic [COORD_BITS-1:0] req_column,
   input  logic [COORD_BITS-1:0] req_row,
   input  logic [7:0]            req_blue,
   input  logic [7:0]            req_green,
   input  logic [7:0]            req_red,
   output logic                  rsp_valid,
   output logic [31:0]           rsp_point_x,
   output logic [31:0]           rsp_point_y,
   output logic [31:0]           rsp_point_z,
   output logic [23:0]           rsp_packed_color,
   output logic                  rsp_zero_weight,
   input  logic                  csr_we,
   input  logic [2:0]            csr_index,
   input  logic [31:0]           csr_wdata
);
   import drp_pkg::*;

   localparam int NumBits = ((COORD_BITS + FRAC_BITS) > 31 ?
                             (COORD_BITS + FRAC_BITS) : 31) + 2;
   localparam int QWidth  = 24 + 2 + DenBits + Lanes * (NumBits + 1);

   cfg_type cfg_ff;

   // Hold the configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.offset_x         <= '0;
         cfg_ff.offset_y         <= '0;
         cfg_ff.focal_term       <= '0;
         cfg_ff.inverse_baseline <= '0;
         cfg_ff.weight_offset    <= WeightReset;
      end else if (csr_we) begin
         case (reg_index_type'(csr_index))
            REG_OFFSET_X:         cfg_ff.offset_x         <= csr_wdata;
            REG_OFFSET_Y:         cfg_ff.offset_y         <= csr_wdata;
            REG_FOCAL_TERM:       cfg_ff.focal_term       <= csr_wdata;
            REG_INVERSE_BASELINE: cfg_ff.inverse_baseline <= csr_wdata;
            REG_WEIGHT_OFFSET:    cfg_ff.weight_offset    <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic                  f_valid;
   logic [DenBits-1:0]    f_den_mag;
   logic                  f_den_neg, f_den_zero;
   logic [NumBits-1:0]    f_num_mag [Lanes];
   logic [Lanes-1:0]      f_num_neg;
   logic [23:0]           f_color;
   logic                  q_full, q_nempty;
   logic [QWidth-1:0]     q_push_data, q_head;

   drp_front #(
      .FracBits (FRAC_BITS),
      .CoordBits(COORD_BITS),
      .NumBits  (NumBits)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (start && !busy),
      .disparity(req_disparity),
      .column   (req_column),
      .row      (req_row),
      .color    ({req_red, req_green, req_blue}),
      .cfg      (cfg_ff),
      .out_valid(f_valid),
      .den_mag  (f_den_mag),
      .den_neg  (f_den_neg),
      .den_zero (f_den_zero),
      .num_mag  (f_num_mag),
      .num_neg  (f_num_neg),
      .out_color(f_color)
   );

   assign q_push_data = {f_color, f_den_zero, f_den_neg, f_den_mag,
                         f_num_neg, f_num_mag[2], f_num_mag[1], f_num_mag[0]};

   drp_queue #(
      .Width(QWidth),
      .Depth(2)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (f_valid),
      .push_data(q_push_data),
      .pop      (q_nempty),
      .head_data(q_head),
      .not_empty(q_nempty),
      .full     (q_full)
   );

   assign busy = q_full;

   logic [23:0]        b_color;
   logic               b_den_zero, b_den_neg;
   logic [DenBits-1:0] b_den_mag;
   logic [Lanes-1:0]   b_num_neg;
   logic [NumBits-1:0] b_num_mag [Lanes];
   logic [31:0]        b_point   [Lanes];

   // Unpack the queue head
   assign {b_color, b_den_zero, b_den_neg, b_den_mag,
           b_num_neg, b_num_mag[2], b_num_mag[1], b_num_mag[0]} = q_head;

   drp_back #(
      .FracBits(FRAC_BITS),
      .NumBits (NumBits)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .in_valid (q_nempty),
      .den_mag  (b_den_mag),
      .den_neg  (b_den_neg),
      .den_zero (b_den_zero),
      .num_mag  (b_num_mag),
      .num_neg  (b_num_neg),
      .in_color (b_color),
      .out_valid(rsp_valid),
      .point    (b_point),
      .out_color(rsp_packed_color),
      .out_zero (rsp_zero_weight)
   );

   assign rsp_point_x = b_point[0];
   assign rsp_point_y = b_point[1];
   assign rsp_point_z = b_point[2];

endmodule

// ===== bench/disparity_to_point_reprojection_checker.sv =====
// Checker that predicts and compares reprojected points for the reprojection block.
`timescale 1ns / 1ps
module disparity_to_point_reprojection_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [7:0]  req_disparity,
   input  logic [11:0] req_column,
   input  logic [11:0] req_row,
   input  logic [7:0]  req_blue,
   input  logic [7:0]  req_green,
   input  logic [7:0]  req_red,
   input  logic        rsp_valid,
   input  logic [31:0] rsp_point_x,
   input  logic [31:0] rsp_point_y,
   input  logic [31:0] rsp_point_z,
   input  logic [23:0] rsp_packed_color,
   input  logic        rsp_zero_weight,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata,
   output int          fail_count,
   output int          pending_points
);
   import drp_pkg::*;

   typedef struct packed {
      logic [31:0] px;
      logic [31:0] py;
      logic [31:0] pz;
      logic [23:0] color;
      logic        zw;
   } point_type;

   cfg_type   calib;
   point_type point_queue[$];

   // Divide a Q16.16 numerator by the weight, truncate and saturate
   function automatic logic [31:0] q_divide(input longint num, input longint den,
                                            inout logic zw);
      longint unsigned mag_n, mag_d, quo;
      logic neg;
      if (den == 0) begin
         zw = 1'b1;
         return (num < 0) ? QMin : QMax;
      end
      neg = (num < 0) != (den < 0);
      mag_n = (num < 0) ? -num : num;
      mag_d = (den < 0) ? -den : den;
      quo = (mag_n << 16) / mag_d;
      if (!neg) return (quo > 64'h7FFF_FFFF) ? QMax : quo[31:0];
      if (quo > 64'h8000_0000) return QMin;
      return 32'(-quo);
   endfunction

   function automatic point_type project_pixel(input logic [7:0] d, input logic [11:0] c,
                                               input logic [11:0] r, input logic [23:0] rgb);
      point_type p;
      longint w, nx, ny, nz;
      logic zw;
      zw = 1'b0;
      w  = longint'($signed(calib.weight_offset)) -
           longint'(d) * longint'($signed(calib.inverse_baseline));
      nx = (longint'(c) <<< 16) + longint'($signed(calib.offset_x));
      ny = (longint'(r) <<< 16) + longint'($signed(calib.offset_y));
      nz = longint'($signed(calib.focal_term));
      p.px = q_divide(nx, w, zw);
      p.py = q_divide(ny, w, zw);
      p.pz = q_divide(nz, w, zw);
      p.color = rgb;
      p.zw = zw;
      return p;
   endfunction

   // Track registers, predict on each transfer, compare each strobe
   always @(posedge clock) begin
      point_type got, want;
      if (reset) begin
         calib.offset_x <= '0;
         calib.offset_y <= '0;
         calib.focal_term <= '0;
         calib.inverse_baseline <= '0;
         calib.weight_offset <= WeightReset;
         point_queue.delete();
         fail_count <= 0;
      end else begin
         if (rsp_valid) begin
            got = '{rsp_point_x, rsp_point_y, rsp_point_z, rsp_packed_color, rsp_zero_weight};
            if (point_queue.size() == 0) begin
               if (fail_count < 10) $display("unexpected point %h", got);
               fail_count <= fail_count + 1;
            end else begin
               want = point_queue.pop_front();
               if (got !== want) begin
                  if (fail_count < 10)
                     $display("mismatch: expected x=%h y=%h z=%h c=%h zw=%b got x=%h y=%h z=%h c=%h zw=%b",
                              want.px, want.py, want.pz, want.color, want.zw,
                              got.px, got.py, got.pz, got.color, got.zw);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (start && !busy && req_disparity != 0)
            point_queue = {point_queue, project_pixel(req_disparity, req_column, req_row,
                                                      {req_red, req_green, req_blue})};
         if (csr_we) begin
            case (csr_index)
               REG_OFFSET_X:         calib.offset_x <= csr_wdata;
               REG_OFFSET_Y:         calib.offset_y <= csr_wdata;
               REG_FOCAL_TERM:       calib.focal_term <= csr_wdata;
               REG_INVERSE_BASELINE: calib.inverse_baseline <= csr_wdata;
               REG_WEIGHT_OFFSET:    calib.weight_offset <= csr_wdata;
               default: ;
            endcase
         end
      end
      pending_points <= point_queue.size();
   end
endmodule

// ===== bench/disparity_to_point_reprojection_tb.sv =====
// Stimulus and verdict for the disparity reprojection block testbench.
`timescale 1ns / 1ps
module disparity_to_point_reprojection_tb;
   import drp_pkg::*;

   localparam int PipeDepth = 38;
   localparam int CycleLimit = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [7:0] req_disparity = '0, req_blue = '0, req_green = '0, req_red = '0;
   logic [11:0] req_column = '0, req_row = '0;
   logic rsp_valid, rsp_zero_weight;
   logic [31:0] rsp_point_x, rsp_point_y, rsp_point_z;
   logic [23:0] rsp_packed_color;
   logic csr_we = 1'b0;
   logic [2:0] csr_index = '0;
   logic [31:0] csr_wdata = '0;
   int fail_count, pending_points;
   int cycle_count = 0;
   int idle_pct = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   disparity_to_point_reprojection DUT (.*);
   disparity_to_point_reprojection_checker checker_inst (.*);

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("FAILURE");
         $finish;
      end
   end

   task automatic write_reg(input reg_index_type idx, input logic [31:0] val);
      @(negedge clock);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // Wait for every point to come out, then for the pipeline to empty
   task automatic drain_points();
      while (pending_points != 0) @(negedge clock);
      repeat (PipeDepth + 4) @(negedge clock);
   endtask

   task automatic send_pixel(input logic [7:0] d, input logic [11:0] c, input logic [11:0] r,
                             input logic [23:0] rgb);
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         start = 1'b0;
         @(negedge clock);
      end
      start = 1'b1;
      req_disparity = d;
      req_column = c;
      req_row = r;
      {req_red, req_green, req_blue} = rgb;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic random_pixel();
      logic [7:0] d;
      d = ($urandom_range(9) == 0) ? 8'd0 : 8'($urandom);
      send_pixel(d, 12'($urandom), 12'($urandom), 24'($urandom));
   endtask

   task automatic set_calib(input logic [31:0] ox, input logic [31:0] oy, input logic [31:0] fz,
                            input logic [31:0] ib, input logic [31:0] wo);
      write_reg(REG_OFFSET_X, ox);
      write_reg(REG_OFFSET_Y, oy);
      write_reg(REG_FOCAL_TERM, fz);
      write_reg(REG_INVERSE_BASELINE, ib);
      write_reg(REG_WEIGHT_OFFSET, wo);
   endtask

   initial begin
      repeat (2) @(negedge clock);
      reset = 1'b0;

      // Directed: defaults, then zero weight, extremes and overflow
      send_pixel(8'd1, 12'd0, 12'd0, 24'h000000);
      send_pixel(8'd0, 12'd5, 12'd5, 24'h123456);
      send_pixel(8'd255, 12'hFFF, 12'hFFF, 24'hFFFFFF);
      @(negedge clock) start = 1'b0;
      drain_points();
      set_calib(32'hFFF0_0000, 32'h8000_0000, 32'h8000_0000, 32'h0001_0000, 32'h0001_0000);
      send_pixel(8'd1, 12'd0, 12'd0, 24'hA5A5A5);
      send_pixel(8'd1, 12'hFFF, 12'd0, 24'h5A5A5A);
      send_pixel(8'd2, 12'hFFF, 12'hFFF, 24'h010203);
      send_pixel(8'd255, 12'd7, 12'd9, 24'hFFFFFF);
      @(negedge clock) start = 1'b0;
      drain_points();
      set_calib(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
      send_pixel(8'd1, 12'hFFF, 12'hFFF, 24'h00FF00);
      send_pixel(8'd255, 12'd0, 12'd0, 24'hFF0000);
      @(negedge clock) start = 1'b0;
      drain_points();
      set_calib(32'h0, 32'h0, 32'h0, 32'h0, 32'h0000_0001);
      send_pixel(8'd128, 12'hFFF, 12'h800, 24'h0000FF);
      @(negedge clock) start = 1'b0;
      drain_points();
      write_reg(reg_index_type'(3'd6), 32'hDEAD_BEEF);
      send_pixel(8'd3, 12'd1, 12'd1, 24'h333333);

      // Random phases with varied sender idling and calibration
      for (int ph = 0; ph < 8; ph++) begin
         @(negedge clock) start = 1'b0;
         drain_points();
         if (ph % 2 == 0)
            set_calib($urandom, $urandom, $urandom, $urandom, $urandom);
         else
            set_calib(32'($urandom_range(1 << 24)) - 32'(1 << 23),
                      32'($urandom_range(1 << 24)) - 32'(1 << 23),
                      32'($urandom_range(1 << 26)),
                      32'($urandom_range(1 << 12)),
                      32'($urandom_range(1 << 24)) + 32'(1 << 20));
         // Receiver stalls do not apply here, so that phase runs with a busy sender
         case (ph % 4)
            0: idle_pct = 0;
            1: idle_pct = 52;
            2: idle_pct = 31;
            default: idle_pct = 0;
         endcase
         for (int k = 0; k < 230; k++) random_pixel();
      end

      @(negedge clock) start = 1'b0;
      drain_points();
      if (fail_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end
endmodule
